// ===== rtl/yfb_pkg.sv =====
// ----------------------------------------------------------------------------
// yfb_pkg: shared types and constants of the YUV fade-to-black unit
// Pixel payload structs, register indexes, fixed-point coefficients and
// the pipeline control bundle.
// ----------------------------------------------------------------------------
package yfb_pkg;

  localparam int NUM_STAGES = 5;

  typedef struct packed {
    logic [9:0] luma_in;
    logic [9:0] cb_in;
    logic [9:0] cr_in;
  } pixel_in_t;

  typedef struct packed {
    logic [9:0] luma_out;
    logic [9:0] cb_out;
    logic [9:0] cr_out;
  } pixel_out_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctl_t;

  // register indexes
  localparam logic REG_FADE_WEIGHT = 1'b0;
  localparam logic REG_MAX_SAMPLE  = 1'b1;

  localparam logic [15:0] FADE_WEIGHT_RESET = 16'd32768;
  localparam logic [9:0]  MAX_SAMPLE_RESET  = 10'd1023;

  // input offsets
  localparam logic signed [10:0] LUMA_OFS   = 11'sd64;
  localparam logic signed [10:0] CHROMA_OFS = 11'sd512;

  // YUV -> RGB, scaled by 1024
  localparam logic signed [12:0] K_RGB_Y  = 13'sd1192;
  localparam logic signed [12:0] K_R_V    = 13'sd1634;
  localparam logic signed [12:0] K_G_U    = -13'sd401;
  localparam logic signed [12:0] K_G_V    = -13'sd833;
  localparam logic signed [12:0] K_B_U    = 13'sd2065;

  // RGB -> YUV, scaled by 1024
  localparam logic signed [10:0] K_Y_R = 11'sd263;
  localparam logic signed [10:0] K_Y_G = 11'sd516;
  localparam logic signed [10:0] K_Y_B = 11'sd100;
  localparam logic signed [10:0] K_U_R = -11'sd152;
  localparam logic signed [10:0] K_U_G = -11'sd298;
  localparam logic signed [10:0] K_U_B = 11'sd450;
  localparam logic signed [10:0] K_V_R = 11'sd450;
  localparam logic signed [10:0] K_V_G = -11'sd377;
  localparam logic signed [10:0] K_V_B = -11'sd73;

  // output offsets at 2^-35 sample resolution
  localparam logic signed [47:0] OUT_OFS_LUMA   = 48'sd1 <<< 41;
  localparam logic signed [47:0] OUT_OFS_CHROMA = 48'sd1 <<< 44;

  // output clamps
  localparam logic [9:0] LUMA_LO   = 10'd64;
  localparam logic [9:0] LUMA_HI   = 10'd940;
  localparam logic [9:0] CHROMA_LO = 10'd64;
  localparam logic [9:0] CHROMA_HI = 10'd960;

endpackage

// ===== rtl/yuv_pixel_fade_to_black_unit.sv =====
// ----------------------------------------------------------------------------
// yuv_pixel_fade_to_black_unit: YUV -> RGB, fade, RGB -> YUV
// Five-stage pipeline that fades one 10-bit YUV 4:4:4 pixel per clock while out_stall is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one pixel per transfer;
//   output channel out_valid/out_stall/out_data carries the faded pixel.
//   A transfer takes place at a clock edge with valid high and stall low.
//   From input transfer to out_valid a pixel passes five register stages:
//   constant products, RGB sum and clamp, weight multiply, matrix products,
//   YUV sum and clamp. Throughput is one pixel per clock while not stalled.
//   Under out_stall the output holds and empty stages keep filling; in_stall
//   rises only once all five stages hold a pixel.
//   The config port writes fade_weight (index 0, Q1.15) and max_sample
//   (index 1) when cfg_we is high; write only while the pipeline is empty.
//   Synchronous reset empties the pipeline and sets fade_weight to 32768
//   and max_sample to 1023.
// ----------------------------------------------------------------------------
module yuv_pixel_fade_to_black_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  yfb_pkg::pixel_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output yfb_pkg::pixel_out_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import yfb_pkg::*;

  function automatic logic [19:0] clamp_rgb(logic signed [23:0] a, logic [19:0] top);
    logic [19:0] res;
    if (a < 24'sd0) begin
      res = '0;
    end else if (a > $signed({4'b0, top})) begin
      res = top;
    end else begin
      res = a[19:0];
    end
    return res;
  endfunction

  function automatic logic signed [47:0] mul_k(logic [35:0] a, logic signed [10:0] k);
    return $signed({12'b0, a}) * 48'(k);
  endfunction

  function automatic logic [9:0] clamp_out(logic signed [47:0] s, logic [9:0] lo,
                                           logic [9:0] hi);
    logic [12:0] v;
    logic [9:0]  res;
    v = s[47:35];
    if (s < $signed({3'b0, lo, 35'b0})) begin
      res = lo;
    end else if (v > {3'b0, hi}) begin
      res = hi;
    end else begin
      res = v[9:0];
    end
    return res;
  endfunction

  logic [15:0] fade_weight;
  logic [9:0]  max_sample;
  pipe_ctl_t   ctl;

  logic signed [10:0] y_s;
  logic signed [10:0] u_s;
  logic signed [10:0] v_s;

  logic signed [22:0] p_y;
  logic signed [22:0] p_vr;
  logic signed [22:0] p_ug;
  logic signed [22:0] p_vg;
  logic signed [22:0] p_ub;

  logic [19:0] rgb_r;
  logic [19:0] rgb_g;
  logic [19:0] rgb_b;

  logic [35:0] w_r;
  logic [35:0] w_g;
  logic [35:0] w_b;

  logic signed [47:0] m_yr, m_yg, m_yb;
  logic signed [47:0] m_ur, m_ug, m_ub;
  logic signed [47:0] m_vr, m_vg, m_vb;

  logic [19:0] rgb_top;
  pixel_out_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_weight <= FADE_WEIGHT_RESET;
      max_sample  <= MAX_SAMPLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FADE_WEIGHT: fade_weight <= cfg_data;
        REG_MAX_SAMPLE:  max_sample  <= cfg_data[9:0];
      endcase
    end
  end

  yfb_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  assign y_s = $signed({1'b0, in_data.luma_in}) - LUMA_OFS;
  assign u_s = $signed({1'b0, in_data.cb_in}) - CHROMA_OFS;
  assign v_s = $signed({1'b0, in_data.cr_in}) - CHROMA_OFS;

  assign rgb_top = {max_sample, 10'b0};

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      p_y  <= 23'(y_s) * 23'(K_RGB_Y);
      p_vr <= 23'(v_s) * 23'(K_R_V);
      p_ug <= 23'(u_s) * 23'(K_G_U);
      p_vg <= 23'(v_s) * 23'(K_G_V);
      p_ub <= 23'(u_s) * 23'(K_B_U);
    end
    if (ctl.load[1]) begin
      rgb_r <= clamp_rgb(24'(p_y) + 24'(p_vr), rgb_top);
      rgb_g <= clamp_rgb(24'(p_y) + 24'(p_ug) + 24'(p_vg), rgb_top);
      rgb_b <= clamp_rgb(24'(p_y) + 24'(p_ub), rgb_top);
    end
    if (ctl.load[2]) begin
      w_r <= 36'(rgb_r) * 36'(fade_weight);
      w_g <= 36'(rgb_g) * 36'(fade_weight);
      w_b <= 36'(rgb_b) * 36'(fade_weight);
    end
    if (ctl.load[3]) begin
      m_yr <= mul_k(w_r, K_Y_R);
      m_yg <= mul_k(w_g, K_Y_G);
      m_yb <= mul_k(w_b, K_Y_B);
      m_ur <= mul_k(w_r, K_U_R);
      m_ug <= mul_k(w_g, K_U_G);
      m_ub <= mul_k(w_b, K_U_B);
      m_vr <= mul_k(w_r, K_V_R);
      m_vg <= mul_k(w_g, K_V_G);
      m_vb <= mul_k(w_b, K_V_B);
    end
    if (ctl.load[4]) begin
      res.luma_out <= clamp_out(m_yr + m_yg + m_yb + OUT_OFS_LUMA, LUMA_LO, LUMA_HI);
      res.cb_out   <= clamp_out(m_ur + m_ug + m_ub + OUT_OFS_CHROMA, CHROMA_LO, CHROMA_HI);
      res.cr_out   <= clamp_out(m_vr + m_vg + m_vb + OUT_OFS_CHROMA, CHROMA_LO, CHROMA_HI);
    end
  end

  assign out_valid = ctl.valid[NUM_STAGES-1];
  assign out_data  = res;

endmodule

// ===== rtl/yfb_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// yfb_pipe_ctrl: valid and load control of the fade pipeline
// Tracks one valid bit per stage and loads a stage whenever it is empty
// or its contents move on, so bubbles are squeezed out under stall.
// ----------------------------------------------------------------------------
module yfb_pipe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_stall,
  output yfb_pkg::pipe_ctl_t ctl
);
  import yfb_pkg::*;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] ready;

  always_comb begin
    ready[NUM_STAGES-1] = !valid[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign in_stall  = !ready[0];
  assign ctl.load  = ready;
  assign ctl.valid = valid;

endmodule

// ===== rtl/yfb_checker.sv =====
// ----------------------------------------------------------------------------
// yfb_checker: port-level checks of the fade unit
// Watches the top-level channels for output range, stall behavior and
// reset emptying.
// ----------------------------------------------------------------------------
module yfb_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input yfb_pkg::pixel_out_t out_data
);
  import yfb_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled transfer dropped or changed");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.luma_out >= LUMA_LO && out_data.luma_out <= LUMA_HI &&
                  out_data.cb_out >= CHROMA_LO && out_data.cb_out <= CHROMA_HI &&
                  out_data.cr_out >= CHROMA_LO && out_data.cr_out <= CHROMA_HI)
    else $error("output sample outside limited range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

  a_in_known: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$isunknown(in_stall))
    else $error("input stall unknown after transfer");

endmodule

bind yuv_pixel_fade_to_black_unit yfb_checker u_yfb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
